/* hw/rtl/ple_pkg.sv */
// Package for the positional list engine.
// Holds operation and status codes and the command struct passed from control to the cells.
// No dependencies.
`default_nettype none
package ple_pkg;

  localparam int unsigned OpWidth     = 3;
  localparam int unsigned PosWidth    = 5;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned CountWidth  = 5;
  localparam int unsigned InValWidth  = 32;

  typedef enum logic [OpWidth-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_POS   = 3'd5
  } ple_op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } ple_status_e;

  // One shift command for the whole row of cells.
  typedef struct packed {
    logic ins;
    logic del;
  } ple_cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/ple_cell.sv */
// One storage cell of the list row.
// Takes the new value, its left or its right neighbour's value, or holds. Uses ple_pkg.
`default_nettype none
module ple_cell
  import ple_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  wire logic         clk_i,
  input  wire ple_cmd_t     cmd_i,
  input  wire logic         hit_i,
  input  wire logic         past_i,
  input  wire logic [W-1:0] new_i,
  input  wire logic [W-1:0] left_i,
  input  wire logic [W-1:0] right_i,
  output logic      [W-1:0] data_o
);

  logic [W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (hit_i) begin
        data_d = new_i;
      end else if (past_i) begin
        data_d = left_i;
      end
    end else if (cmd_i.del) begin
      // The removed slot and every slot behind it close the gap.
      if (hit_i || past_i) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

/* hw/rtl/ple_ctrl.sv */
// Operation decode for the positional list engine.
// Checks position, fullness and emptiness and yields the shift command. Uses ple_pkg.
`default_nettype none
module ple_ctrl
  import ple_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic [OpWidth-1:0]             op_i,
  input  wire logic [PosWidth-1:0]            pos_i,
  input  wire logic [$clog2(DEPTH+1)-1:0]     occ_i,
  output ple_status_e                         status_o,
  output ple_cmd_t                            cmd_o,
  output logic      [$clog2(DEPTH)-1:0]       idx_o,
  output logic      [$clog2(DEPTH+1)-1:0]     occ_next_o
);

  localparam int unsigned CW   = $clog2(DEPTH+1);
  localparam int unsigned IW   = $clog2(DEPTH);
  localparam int unsigned CMPW = ((CW > PosWidth) ? CW : PosWidth) + 1;

  logic [CMPW-1:0] pos_w, occ_w;
  logic            full, empty;

  assign pos_w = CMPW'(pos_i);
  assign occ_w = CMPW'(occ_i);
  assign full  = (occ_i == CW'(DEPTH));
  assign empty = (occ_i == '0);

  always_comb begin
    status_o = ST_DONE;
    cmd_o    = '0;
    idx_o    = '0;
    case (op_i)
      OP_INS_FRONT: begin
        if (full) begin
          status_o = ST_FULL;
        end else begin
          cmd_o.ins = 1'b1;
        end
      end
      OP_INS_BACK: begin
        if (full) begin
          status_o = ST_FULL;
        end else begin
          cmd_o.ins = 1'b1;
          idx_o     = IW'(occ_i);
        end
      end
      OP_INS_POS: begin
        if (pos_w == '0 || pos_w > occ_w + CMPW'(1)) begin
          status_o = ST_BADPOS;
        end else if (full) begin
          status_o = ST_FULL;
        end else begin
          cmd_o.ins = 1'b1;
          idx_o     = IW'(pos_w - CMPW'(1));
        end
      end
      OP_DEL_FRONT: begin
        if (empty) begin
          status_o = ST_EMPTY;
        end else begin
          cmd_o.del = 1'b1;
        end
      end
      OP_DEL_BACK: begin
        if (empty) begin
          status_o = ST_EMPTY;
        end else begin
          cmd_o.del = 1'b1;
          idx_o     = IW'(occ_i - CW'(1));
        end
      end
      OP_DEL_POS: begin
        if (pos_w == '0 || pos_w > occ_w) begin
          status_o = ST_BADPOS;
        end else begin
          cmd_o.del = 1'b1;
          idx_o     = IW'(pos_w - CMPW'(1));
        end
      end
      default: begin
        // Unused codes leave the list alone and report done.
        status_o = ST_DONE;
      end
    endcase
  end

  always_comb begin
    occ_next_o = occ_i;
    if (cmd_o.ins) begin
      occ_next_o = occ_i + CW'(1);
    end else if (cmd_o.del) begin
      occ_next_o = occ_i - CW'(1);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/positional_list_engine.sv */
// Positional list engine: a row of DEPTH cells that shift together on insert or delete.
// Results are registered: a beat accepted at a clock edge has its result in the output register from that edge on.
// Throughput: one beat per cycle while each result is taken; every cell moves in the same cycle as the decode.
// The input stalls only while a result sits in the output register and is not being taken.
// Reset clears the occupancy and the output valid flag; cell contents are not reset.
// Depends on ple_pkg, ple_ctrl and ple_cell.
`default_nettype none
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [OpWidth-1:0]     operation_i,
  input  wire logic [PosWidth-1:0]    position_i,
  input  wire logic [InValWidth-1:0]  value_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic      [StatusWidth-1:0] status_o,
  output logic      [CountWidth-1:0]  element_count_o
);

  localparam int unsigned CW = $clog2(DEPTH+1);
  localparam int unsigned IW = $clog2(DEPTH);

  logic [CW-1:0]           occ_q, occ_d, occ_next;
  logic                    out_valid_q, out_valid_d;
  logic [StatusWidth-1:0]  status_q, status_d;
  logic [CountWidth-1:0]   count_q, count_d;
  logic                    accept;
  ple_status_e             status;
  ple_cmd_t                cmd, cmd_gated;
  logic [IW-1:0]           idx;
  logic [63:0]             value_ext;
  logic [VALUE_WIDTH-1:0]  new_val;
  logic [VALUE_WIDTH-1:0]  cell_q [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign value_ext = {32'b0, value_i};
  assign new_val   = value_ext[VALUE_WIDTH-1:0];

  ple_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .op_i      (operation_i),
    .pos_i     (position_i),
    .occ_i     (occ_q),
    .status_o  (status),
    .cmd_o     (cmd),
    .idx_o     (idx),
    .occ_next_o(occ_next)
  );

  // The row only moves on an accepted beat.
  assign cmd_gated.ins = cmd.ins && accept;
  assign cmd_gated.del = cmd.del && accept;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = new_val;
    end else begin : g_mid
      assign left = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_q[i];
    end else begin : g_inner
      assign right = cell_q[i+1];
    end
    ple_cell #(
      .W(VALUE_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd_gated),
      .hit_i  (idx == IW'(i)),
      .past_i (IW'(i) > idx),
      .new_i  (new_val),
      .left_i (left),
      .right_i(right),
      .data_o (cell_q[i])
    );
  end

  always_comb begin
    occ_d       = occ_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    count_d     = count_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      occ_d       = occ_next;
      out_valid_d = 1'b1;
      status_d    = status;
      count_d     = CountWidth'(occ_next);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    count_q  <= count_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign element_count_o = count_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(DEPTH))
    else $error("occupancy exceeds depth");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd.ins |=> occ_q == $past(occ_q) + CW'(1))
    else $error("insert did not grow the list");

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> element_count_o == CountWidth'(occ_q))
    else $error("reported count differs from occupancy");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && status == ST_FULL |=> occ_q == CW'(DEPTH))
    else $error("full reported while list not full");

endmodule
`default_nettype wire

/* tb/sv/tb_positional_list_engine.sv */
// Self-checking testbench for positional_list_engine: directed table, then random list traffic.
// Each accepted beat is predicted against a shadow copy of the list and its count.
// Depends on ple_pkg and the positional_list_engine RTL.
`timescale 1ns / 100ps
module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int unsigned Depth        = 16;
  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned ClkPeriod    = 4;
  localparam int unsigned ResetCycles  = 4;
  localparam int unsigned RandomBeats  = 800;
  localparam int unsigned SqueezeAfter = 300;
  localparam int unsigned SqueezeLen   = 300;
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned DrainCycles  = 4;
  localparam int unsigned ReportMax    = 10;

  // Operation codes outside the package enum; the block treats them as no-ops.
  localparam logic [OpWidth-1:0] OpSpare6 = 3'd6;
  localparam logic [OpWidth-1:0] OpSpare7 = 3'd7;

  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [CountWidth-1:0]  count;
  } list_outcome_t;

  typedef struct {
    logic [OpWidth-1:0]    op;
    logic [PosWidth-1:0]   pos;
    logic [InValWidth-1:0] val;
    int unsigned           reps;
    bit                    typed;
    list_outcome_t         want;
  } stim_row_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic [OpWidth-1:0]     operation_i = '0;
  logic [PosWidth-1:0]    position_i  = '0;
  logic [InValWidth-1:0]  value_i     = '0;
  logic                   out_ready_i = 1'b0;
  logic                   in_ready_o;
  logic                   out_valid_o;
  logic [StatusWidth-1:0] status_o;
  logic [CountWidth-1:0]  element_count_o;

  // Travels with each input beat: a hand-written expectation replaces the prediction.
  bit            beat_typed = 1'b0;
  list_outcome_t beat_want  = '0;

  logic [ValueWidth-1:0] shadow_list [$];
  list_outcome_t         outcome_q [$];
  stim_row_t             directed_rows [$];
  int unsigned           fail_count    = 0;
  int unsigned           results_taken = 0;
  int unsigned           idle_cycles   = 0;

  positional_list_engine #(
    .DEPTH      (Depth),
    .VALUE_WIDTH(ValueWidth)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .element_count_o(element_count_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Applies one operation to the shadow list and returns the status and the new count.
  function automatic list_outcome_t predict_list_op(logic [OpWidth-1:0] op,
                                                    logic [PosWidth-1:0] pos,
                                                    logic [InValWidth-1:0] val);
    list_outcome_t res;
    int unsigned   occ;
    int unsigned   p;
    occ = shadow_list.size();
    p   = 32'(pos);
    res.status = ST_DONE;
    case (op)
      OP_INS_FRONT: begin
        if (occ >= Depth) res.status = ST_FULL;
        else shadow_list.push_front(val[ValueWidth-1:0]);
      end
      OP_INS_BACK: begin
        if (occ >= Depth) res.status = ST_FULL;
        else shadow_list.push_back(val[ValueWidth-1:0]);
      end
      OP_INS_POS: begin
        // The position is judged before fullness.
        if (p < 1 || p > occ + 1) res.status = ST_BADPOS;
        else if (occ >= Depth) res.status = ST_FULL;
        else shadow_list.insert(p - 1, val[ValueWidth-1:0]);
      end
      OP_DEL_FRONT: begin
        if (occ == 0) res.status = ST_EMPTY;
        else void'(shadow_list.pop_front());
      end
      OP_DEL_BACK: begin
        if (occ == 0) res.status = ST_EMPTY;
        else void'(shadow_list.pop_back());
      end
      OP_DEL_POS: begin
        if (p < 1 || p > occ) res.status = ST_BADPOS;
        else shadow_list.delete(p - 1);
      end
      default: ;
    endcase
    res.count = CountWidth'(shadow_list.size());
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic note_mismatch(string what, int unsigned want, int unsigned got);
    fail_count++;
    if (fail_count <= ReportMax) begin
      $display("tb: mismatch, %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  task automatic add_row(logic [OpWidth-1:0] op, logic [PosWidth-1:0] pos,
                         logic [InValWidth-1:0] val, int unsigned reps, bit typed,
                         logic [StatusWidth-1:0] st, logic [CountWidth-1:0] cnt);
    stim_row_t row;
    row.op   = op;
    row.pos  = pos;
    row.val  = val;
    row.reps = reps;
    row.typed       = typed;
    row.want.status = st;
    row.want.count  = cnt;
    directed_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the gap that follows.
  task automatic drive_beat(logic [OpWidth-1:0] op, logic [PosWidth-1:0] pos,
                            logic [InValWidth-1:0] val, bit typed, list_outcome_t want,
                            int unsigned gap);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    position_i  <= pos;
    value_i     <= val;
    beat_typed  <= typed;
    beat_want   <= want;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    list_outcome_t got;
    list_outcome_t want;
    bit            moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        got.status = status_o;
        got.count  = element_count_o;
        results_taken++;
        if (outcome_q.size() == 0) begin
          note_mismatch("result with nothing awaited, status", 0, 32'(got.status));
        end else begin
          want = outcome_q.pop_front();
          if (got.status !== want.status) begin
            note_mismatch("status", 32'(want.status), 32'(got.status));
          end
          if (got.count !== want.count) begin
            note_mismatch("element_count", 32'(want.count), 32'(got.count));
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        want = predict_list_op(operation_i, position_i, value_i);
        if (beat_typed) want = beat_want;
        outcome_q.push_back(want);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold-off that backs up the input.
  initial begin
    int unsigned hold;
    int unsigned cyc;
    bit          squeezed;
    hold     = 0;
    cyc      = 0;
    squeezed = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (!squeezed && results_taken >= SqueezeAfter) begin
        hold     = SqueezeLen;
        squeezed = 1'b1;
      end else if (hold == 0 && ((cyc / 256) % 4) != 3 && $urandom_range(0, 99) < 20) begin
        hold = 1 + idle_len();
      end
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(negedge clk_i);
    $display("tb: failure");
    $finish;
  end

  initial begin
    stim_row_t         row;
    list_outcome_t     none;
    logic [OpWidth-1:0]  op;
    logic [PosWidth-1:0] pos;
    int unsigned       n;
    int unsigned       occ;
    int unsigned       bias;
    int unsigned       gap;
    int unsigned       phase;
    none = '0;

    // Empty list: deletes, bad positions and the spare codes.
    add_row(OP_DEL_FRONT, 5'd0,  32'h0000_0000, 1, 1'b1, ST_EMPTY,  5'd0);
    add_row(OP_DEL_BACK,  5'd0,  32'h0000_0000, 1, 1'b1, ST_EMPTY,  5'd0);
    add_row(OP_DEL_POS,   5'd1,  32'h0000_0000, 1, 1'b1, ST_BADPOS, 5'd0);
    add_row(OP_INS_POS,   5'd0,  32'h1234_5678, 1, 1'b1, ST_BADPOS, 5'd0);
    add_row(OP_INS_POS,   5'd2,  32'h1234_5678, 1, 1'b1, ST_BADPOS, 5'd0);
    add_row(OpSpare6,     5'd31, 32'hFFFF_FFFF, 1, 1'b1, ST_DONE,   5'd0);
    add_row(OpSpare7,     5'd1,  32'h0000_0001, 1, 1'b1, ST_DONE,   5'd0);
    // Value extremes through every insert flavour, then bad and good delete positions.
    add_row(OP_INS_FRONT, 5'd0,  32'h8000_0000, 1, 1'b1, ST_DONE,   5'd1);
    add_row(OP_INS_BACK,  5'd31, 32'h7FFF_FFFF, 1, 1'b1, ST_DONE,   5'd2);
    add_row(OP_INS_POS,   5'd3,  32'hFFFF_FFFF, 1, 1'b1, ST_DONE,   5'd3);
    add_row(OP_INS_POS,   5'd1,  32'h0000_0000, 1, 1'b1, ST_DONE,   5'd4);
    add_row(OP_DEL_POS,   5'd31, 32'h0000_0000, 1, 1'b1, ST_BADPOS, 5'd4);
    add_row(OP_DEL_POS,   5'd0,  32'h0000_0000, 1, 1'b1, ST_BADPOS, 5'd4);
    add_row(OP_DEL_POS,   5'd4,  32'h0000_0000, 1, 1'b1, ST_DONE,   5'd3);
    // Fill to the brim, knock on the full store, then delete at and past the end.
    add_row(OP_INS_BACK,  5'd0,  32'hA5A5_5A5A, 13, 1'b0, ST_DONE,  5'd0);
    add_row(OP_INS_FRONT, 5'd0,  32'h0000_0001, 1, 1'b1, ST_FULL,   5'd16);
    add_row(OP_INS_BACK,  5'd0,  32'h0000_0002, 1, 1'b1, ST_FULL,   5'd16);
    add_row(OP_INS_POS,   5'd17, 32'h0000_0003, 1, 1'b1, ST_FULL,   5'd16);
    add_row(OP_INS_POS,   5'd18, 32'h0000_0004, 1, 1'b1, ST_BADPOS, 5'd16);
    add_row(OP_DEL_POS,   5'd16, 32'h0000_0000, 1, 1'b1, ST_DONE,   5'd15);
    add_row(OP_DEL_POS,   5'd17, 32'h0000_0000, 1, 1'b1, ST_BADPOS, 5'd15);
    add_row(OP_DEL_BACK,  5'd0,  32'h0000_0000, 1, 1'b1, ST_DONE,   5'd14);
    // Drain back to empty.
    add_row(OP_DEL_FRONT, 5'd0,  32'h0000_0000, 13, 1'b0, ST_DONE,  5'd0);
    add_row(OP_DEL_POS,   5'd1,  32'h0000_0000, 1, 1'b1, ST_DONE,   5'd0);
    add_row(OP_DEL_FRONT, 5'd0,  32'h0000_0000, 1, 1'b1, ST_EMPTY,  5'd0);

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      repeat (row.reps) drive_beat(row.op, row.pos, row.val, row.typed, row.want, idle_len());
    end

    // Random traffic in phases that lean towards filling or draining the list.
    n = 0;
    while (n < RandomBeats) begin
      phase = (n / 64) % 4;
      case (phase)
        0: bias = 75;
        1: bias = 30;
        2: bias = 60;
        default: bias = 25;
      endcase
      occ = shadow_list.size();
      if ($urandom_range(0, 99) < 3) begin
        op = $urandom_range(0, 1) ? OpSpare6 : OpSpare7;
      end else begin
        if ($urandom_range(0, 99) < bias) begin
          op = OpWidth'($urandom_range(OP_INS_FRONT, OP_INS_POS));
        end else begin
          op = OpWidth'($urandom_range(OP_DEL_FRONT, OP_DEL_POS));
        end
        n++;
      end
      if ($urandom_range(0, 99) < 15) pos = PosWidth'($urandom_range(0, 31));
      else if (op == OP_INS_POS) pos = PosWidth'($urandom_range(1, occ + 1));
      else pos = (occ == 0) ? 5'd1 : PosWidth'($urandom_range(1, occ));
      gap = (phase == 2) ? 0 : idle_len();
      drive_beat(op, pos, $urandom, 1'b0, none, gap);
    end
    in_valid_i <= 1'b0;

    while (outcome_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (outcome_q.size() != 0) note_mismatch("results still awaited", 0, outcome_q.size());
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
